/* src/prp_pkg.sv */
// package for the permutation rank and parity block
// constants, field widths, factorial table and size clamp; no dependencies

package prp_pkg;

  localparam int MaxElements = 16;

  // widths of the ports and of the internal state
  localparam int ValueW = 5;
  localparam int SizeW  = 5;
  localparam int RankW  = 45;
  localparam int CountW = $clog2(MaxElements + 1);
  localparam int IdxW   = $clog2(MaxElements);
  localparam int DigitW = $clog2(MaxElements + 1);
  localparam int ProdW  = RankW + DigitW;

  // factorials 0! .. 15!, all fit in the rank width
  localparam logic [RankW-1:0] FactTable [MaxElements] = '{
    45'd1, 45'd1, 45'd2, 45'd6, 45'd24, 45'd120, 45'd720, 45'd5040,
    45'd40320, 45'd362880, 45'd3628800, 45'd39916800, 45'd479001600,
    45'd6227020800, 45'd87178291200, 45'd1307674368000
  };

  // size as written, clamped to 1 .. MaxElements
  function automatic logic [CountW-1:0] clamp_size_f(input logic [SizeW-1:0] size);
    logic [CountW-1:0] n;
    n = CountW'(size);
    if (size == '0) begin
      n = CountW'(1);
    end else if (32'(size) > MaxElements) begin
      n = CountW'(MaxElements);
    end
    return n;
  endfunction

endpackage

/* src/permutation_rank_and_parity.sv */
// permutation rank and parity: lehmer digits, rank accumulation, parity, invalid flag
// depends on prp_pkg
//
// pipeline: an element is registered at the input; the result register then takes the
// result of a permutation's last element from there, once it has room
// throughput: one element per cycle, results stream back to back; only a last element
// facing a full and stalled result register waits, and it stalls the input meanwhile
// reset: size 16, state cleared, both pipeline registers empty
// a size write also clears the partial permutation

module permutation_rank_and_parity
  import prp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: number of elements per permutation
  input  logic              cfg_we_i,
  input  logic [SizeW-1:0]  cfg_size_in_use_i,
  // element input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] element_value_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RankW-1:0]  rank_o,
  output logic              parity_odd_o,
  output logic              invalid_o
);

  // effective size n
  logic [CountW-1:0] n_q;

  // input register
  logic              in_valid_q;
  logic [ValueW-1:0] elem_q;

  // permutation state
  logic [MaxElements-1:0] used_q, used_d;
  logic [CountW-1:0]      pos_q, pos_d;
  logic [RankW-1:0]       rank_q, rank_d;
  logic                   parity_q, parity_d;
  logic                   err_q, err_d;

  // result register
  logic              out_valid_q;
  logic [RankW-1:0]  out_rank_q;
  logic              out_parity_q;
  logic              out_err_q;

  // datapath
  logic [MaxElements-1:0] n_mask;
  logic [MaxElements-1:0] below;
  logic [MaxElements-1:0] sel;
  logic [MaxElements-1:0] cand;
  logic [DigitW-1:0]      digit;
  logic [CountW-1:0]      pos_eff;
  logic [CountW-1:0]      remaining;
  logic [ProdW-1:0]       prod;
  logic                   bad_elem;
  logic                   last;
  logic                   advance;
  logic                   in_accept;

  always_comb begin
    for (int i = 0; i < MaxElements; i++) begin
      // value i+1 is one of 1..n
      n_mask[i] = (CountW'(i) < n_q);
      // value i+1 lies below the element
      below[i]  = (ValueW'(i + 1) < elem_q);
      // element names value i+1 and is in range
      sel[i]    = (elem_q == ValueW'(i + 1)) && (CountW'(i) < n_q);
    end
    cand  = ~used_q & below & n_mask;
    digit = DigitW'($countones(cand));

    // position is always below n, the clamp only guards the table index
    pos_eff   = (pos_q >= n_q) ? n_q - CountW'(1) : pos_q;
    remaining = n_q - CountW'(1) - pos_eff;
    prod      = ProdW'(digit) * ProdW'(FactTable[remaining[IdxW-1:0]]);

    // zero, out of range, or already seen
    bad_elem = (sel == '0) || ((used_q & sel) != '0);
    last     = ((pos_eff + CountW'(1)) == n_q);

    used_d   = used_q | sel;
    pos_d    = pos_eff + CountW'(1);
    rank_d   = rank_q + prod[RankW-1:0];
    parity_d = parity_q ^ digit[0];
    err_d    = err_q | bad_elem;
  end

  // an element without a result always moves on; the last one waits for
  // room in the result register
  assign advance    = in_valid_q && (!last || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      elem_q <= element_value_i;
    end
  end

  // size register and permutation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= CountW'(MaxElements);
      used_q   <= '0;
      pos_q    <= '0;
      rank_q   <= '0;
      parity_q <= 1'b0;
      err_q    <= 1'b0;
    end else if (cfg_we_i) begin
      // new size drops any partial permutation
      n_q      <= clamp_size_f(cfg_size_in_use_i);
      used_q   <= '0;
      pos_q    <= '0;
      rank_q   <= '0;
      parity_q <= 1'b0;
      err_q    <= 1'b0;
    end else if (advance) begin
      if (last) begin
        used_q   <= '0;
        pos_q    <= '0;
        rank_q   <= '0;
        parity_q <= 1'b0;
        err_q    <= 1'b0;
      end else begin
        used_q   <= used_d;
        pos_q    <= pos_d;
        rank_q   <= rank_d;
        parity_q <= parity_d;
        err_q    <= err_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last) begin
      // rank is 1-based
      out_rank_q   <= rank_d + RankW'(1);
      out_parity_q <= parity_d;
      out_err_q    <= err_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rank_o       = out_rank_q;
  assign parity_odd_o = out_parity_q;
  assign invalid_o    = out_err_q;

  // position never reaches n between permutations
  a_pos_below_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < n_q)
    else $error("position reached size");

  // no value above n is ever marked as seen
  a_used_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q & ~n_mask) == '0)
    else $error("bitmap holds value above size");

  // each element marks at most one value
  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CountW'($countones(used_q)) <= pos_q)
    else $error("bitmap holds more values than elements taken");

  // the last element always lands in the result register
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last) |=> out_valid_q)
    else $error("result lost");

endmodule
